FILE: rtl/bspl_pkg.sv
package bspl_pkg;

    localparam int NUM_INTERIOR = 15;
    localparam int MAX_DEGREE   = 5;
    localparam int FRAC_BITS    = 16;

    localparam int TABLE_DEPTH = MAX_DEGREE + NUM_INTERIOR;
    localparam int KNOTS_MAX   = 2 * MAX_DEGREE + NUM_INTERIOR;
    localparam int LANES       = MAX_DEGREE + 1;

    localparam int DEG_W   = 3;
    localparam int T_W     = FRAC_BITS + 1;
    localparam int TT_W    = $clog2(NUM_INTERIOR + 1) + FRAC_BITS + 1;
    localparam int M_W     = TT_W - FRAC_BITS;
    localparam int KN_W    = $clog2(NUM_INTERIOR + 2);
    localparam int IDX_W   = $clog2(KNOTS_MAX) + 1;
    localparam int SPAN_W  = 3;
    localparam int CIDX_W  = 5;
    localparam int COEF_W  = 32;
    localparam int LANE_W  = $clog2(LANES);
    localparam int RCP_SH  = TT_W + SPAN_W;
    localparam int RCP_W   = RCP_SH + 1;
    localparam int PROD_W  = TT_W + RCP_W;
    localparam int ACC_W   = TT_W + T_W + 1;
    localparam int TERM_W  = COEF_W + T_W + 1;
    localparam int SUM_W   = 40;
    localparam int OUT_W   = 48;

    localparam logic [T_W-1:0] ONE = T_W'(1) << FRAC_BITS;

    // floor(2^RCP_SH / d) for the knot spans 1..5
    localparam logic [RCP_W-1:0] RECIP_TBL [8] = '{
        RCP_W'(0),
        RCP_W'((64'd1 << RCP_SH) / 1),
        RCP_W'((64'd1 << RCP_SH) / 2),
        RCP_W'((64'd1 << RCP_SH) / 3),
        RCP_W'((64'd1 << RCP_SH) / 4),
        RCP_W'((64'd1 << RCP_SH) / 5),
        RCP_W'(0),
        RCP_W'(0)
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INT_LD,
        ST_INIT,
        ST_LANE_RD,
        ST_DIV,
        ST_CORR,
        ST_MAC,
        ST_SUM_RD,
        ST_SUM_MUL,
        ST_SUM_ACC,
        ST_DONE
    } state_t;

    // knot j as an integer numerator over NUM_INTERIOR+1
    function automatic logic [KN_W-1:0] knot_num(input logic [DEG_W-1:0] deg,
                                                 input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] d6;
        d6 = IDX_W'(deg);
        if (idx < d6)
            return '0;
        else if (idx < d6 + IDX_W'(NUM_INTERIOR))
            return KN_W'(idx - d6 + IDX_W'(1));
        else
            return KN_W'(NUM_INTERIOR + 1);
    endfunction

endpackage

FILE: rtl/bspl_ram.sv
module bspl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bspline_basis_weighted_sum.sv
// Write request: ST_DONE registers the result once the output register is free.
// Evaluate request at t >= 1.0: the result is the intercept, registered through ST_DONE.
// Evaluate otherwise: a recursion over L = (d+1)(d+2)/2 - 1 lanes, each weight
// set by one shared divide/multiply step, then a sum over d+1 basis values. One request at a time.
// Reset (rst_n low, asynchronous): degree 3, coefficient table reads as zero, no result pending.
module bspline_basis_weighted_sum
    import bspl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [DEG_W-1:0]         spline_degree,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic                     req_type,
    input  logic [T_W-1:0]           point_t,
    input  logic [CIDX_W-1:0]        coeff_index,
    input  logic signed [COEF_W-1:0] coeff_value,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic signed [OUT_W-1:0]  spline_value,
    output logic                     was_write
);

    state_t                    state_reg, state_next;
    logic [DEG_W-1:0]          deg_cfg_reg;
    logic [T_W-1:0]            t_reg, t_next;
    logic [CIDX_W-1:0]         s_reg, s_next;
    logic [DEG_W-1:0]          k_reg, k_next;
    logic [LANE_W-1:0]         j_reg, j_next;
    logic                      half_reg, half_next;
    logic [T_W-1:0]            held_reg, held_next;
    logic [T_W-1:0]            rdv_reg, rdv_next;
    logic [TT_W-1:0]           num1_reg, num1_next, num2_reg, num2_next;
    logic [SPAN_W-1:0]         d1_reg, d1_next, d2_reg, d2_next;
    logic                      en1_reg, en1_next, en2_reg, en2_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic [TT_W-1:0]           w_reg, w_next;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic                      bok_reg, bok_next;
    logic signed [TERM_W-1:0]  term_reg, term_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic                      wr_reg, wr_next;
    logic                      cvld_rd_reg, cvld_rd_next;
    logic [TABLE_DEPTH-1:0]    vbits_reg, vbits_next;
    logic                      res_valid_reg, res_valid_next;
    logic signed [OUT_W-1:0]   res_value_reg, res_value_next;
    logic                      res_write_reg, res_write_next;

    logic                      c_we, c_re;
    logic [CIDX_W-1:0]         c_addr;
    logic [COEF_W-1:0]         c_wdata, c_q;
    logic                      b_we, b_re;
    logic [LANE_W-1:0]         b_addr;
    logic [T_W-1:0]            b_wdata, b_q;

    logic                      req_acc;
    logic [DEG_W-1:0]          deg;
    logic [IDX_W-1:0]          nk;
    logic [TT_W-1:0]           tt_in, tt;
    logic [IDX_W-1:0]          iu;
    logic                      i_ok;
    logic [KN_W-1:0]           mi, mi1, mik1, mik;
    logic [TT_W-1:0]           base, top;
    logic [TT_W-1:0]           num_sel;
    logic [SPAN_W-1:0]         d_sel;
    logic [TT_W:0]             q0;
    logic [TT_W+SPAN_W:0]      rem;
    logic [T_W-1:0]            bas;
    logic [ACC_W-1:0]          mac_prod, acc_sum;
    logic [CIDX_W-1:0]         bsum;

    bspl_ram #(.WIDTH(COEF_W), .DEPTH(TABLE_DEPTH)) u_coef_ram (
        .clk   (clk),
        .we    (c_we),
        .re    (c_re),
        .addr  (c_addr),
        .wdata (c_wdata),
        .rdata (c_q)
    );

    bspl_ram #(.WIDTH(T_W), .DEPTH(LANES)) u_basis_ram (
        .clk   (clk),
        .we    (b_we),
        .re    (b_re),
        .addr  (b_addr),
        .wdata (b_wdata),
        .rdata (b_q)
    );

    assign req_stall    = (state_reg != ST_IDLE);
    assign req_acc      = req_valid && !req_stall;
    assign res_valid    = res_valid_reg;
    assign spline_value = res_value_reg;
    assign was_write    = res_write_reg;

    always_comb
    begin
        if (deg_cfg_reg == '0)
            deg = DEG_W'(1);
        else if (deg_cfg_reg > DEG_W'(MAX_DEGREE))
            deg = DEG_W'(MAX_DEGREE);
        else
            deg = deg_cfg_reg;
    end

    assign nk    = IDX_W'(2) * IDX_W'(deg) + IDX_W'(NUM_INTERIOR);
    assign tt_in = TT_W'(point_t) * TT_W'(NUM_INTERIOR + 1);
    assign tt    = TT_W'(t_reg) * TT_W'(NUM_INTERIOR + 1);

    // lane j of the window holds basis index s - j
    assign iu   = IDX_W'(s_reg) - IDX_W'(j_reg);
    assign i_ok = (s_reg >= CIDX_W'(j_reg)) && ((iu + IDX_W'(k_reg)) < nk);
    assign mi   = knot_num(deg, iu);
    assign mi1  = knot_num(deg, iu + IDX_W'(1));
    assign mik1 = knot_num(deg, iu + IDX_W'(k_reg) - IDX_W'(1));
    assign mik  = knot_num(deg, iu + IDX_W'(k_reg));
    assign base = TT_W'(mi) << FRAC_BITS;
    assign top  = TT_W'(mik) << FRAC_BITS;

    assign num_sel = half_reg ? num2_reg : num1_reg;
    assign d_sel   = half_reg ? d2_reg : d1_reg;

    // reciprocal quotient is low by at most one; fix with one compare
    assign q0  = prod_reg[PROD_W-1 -: (TT_W + 1)];
    assign rem = (TT_W+SPAN_W+1)'(num_sel) - (TT_W+SPAN_W+1)'(q0 * (TT_W+1)'(d_sel));

    assign bas      = half_reg ? rdv_reg : held_reg;
    assign mac_prod = ACC_W'(w_reg) * ACC_W'(bas);
    assign acc_sum  = acc_reg + mac_prod;

    assign bsum = s_reg - CIDX_W'(j_reg) + CIDX_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        s_next         = s_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        half_next      = half_reg;
        held_next      = held_reg;
        rdv_next       = rdv_reg;
        num1_next      = num1_reg;
        num2_next      = num2_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        en1_next       = en1_reg;
        en2_next       = en2_reg;
        prod_next      = prod_reg;
        w_next         = w_reg;
        acc_next       = acc_reg;
        bok_next       = bok_reg;
        term_next      = term_reg;
        sum_next       = sum_reg;
        wr_next        = wr_reg;
        cvld_rd_next   = cvld_rd_reg;
        vbits_next     = vbits_reg;
        res_value_next = res_value_reg;
        res_write_next = res_write_reg;
        res_valid_next = res_valid_reg && res_stall;
        c_we    = 1'b0;
        c_re    = 1'b0;
        c_addr  = '0;
        c_wdata = coeff_value;
        b_we    = 1'b0;
        b_re    = 1'b0;
        b_addr  = '0;
        b_wdata = ONE;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    if (req_type)
                    begin
                        if (coeff_index < CIDX_W'(TABLE_DEPTH))
                        begin
                            c_we   = 1'b1;
                            c_addr = coeff_index;
                            vbits_next[coeff_index] = 1'b1;
                        end
                        wr_next    = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // fetch the intercept
                        c_re         = 1'b1;
                        c_addr       = '0;
                        cvld_rd_next = vbits_reg[0];
                        wr_next      = 1'b0;
                        t_next       = point_t;
                        s_next       = CIDX_W'(deg) - CIDX_W'(1)
                                       + CIDX_W'(tt_in[TT_W-1 -: M_W]);
                        state_next   = ST_INT_LD;
                    end
                end
            end

            ST_INT_LD:
            begin
                sum_next = cvld_rd_reg ? SUM_W'($signed(c_q)) : '0;
                if (t_reg >= ONE)
                    state_next = ST_DONE;
                else
                    state_next = ST_INIT;
            end

            ST_INIT:
            begin
                b_we       = 1'b1;
                b_addr     = '0;
                b_wdata    = ONE;
                k_next     = DEG_W'(2);
                j_next     = LANE_W'(1);
                held_next  = '0;
                half_next  = 1'b0;
                state_next = ST_LANE_RD;
            end

            ST_LANE_RD:
            begin
                b_re      = (j_reg != '0);
                b_addr    = (j_reg != '0) ? j_reg - LANE_W'(1) : '0;
                num1_next = (tt > base) ? tt - base : '0;
                num2_next = (top > tt) ? top - tt : '0;
                d1_next   = SPAN_W'(mik1 - mi);
                d2_next   = SPAN_W'(mik - mi1);
                en1_next  = i_ok && (SPAN_W'(mik1 - mi) != '0);
                en2_next  = i_ok && (SPAN_W'(mik - mi1) != '0);
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (!half_reg)
                    rdv_next = (j_reg == '0) ? '0 : b_q;
                prod_next  = PROD_W'(num_sel) * PROD_W'(RECIP_TBL[d_sel]);
                state_next = ST_CORR;
            end

            ST_CORR:
            begin
                if ((half_reg ? en2_reg : en1_reg) == 1'b0)
                    w_next = '0;
                else if (rem >= (TT_W+SPAN_W+1)'(d_sel))
                    w_next = TT_W'(q0 + (TT_W+1)'(1));
                else
                    w_next = TT_W'(q0);
                state_next = ST_MAC;
            end

            ST_MAC:
            begin
                if (!half_reg)
                begin
                    acc_next   = mac_prod;
                    half_next  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    b_we      = 1'b1;
                    b_addr    = j_reg;
                    b_wdata   = acc_sum[FRAC_BITS +: T_W];
                    half_next = 1'b0;
                    if (j_reg == '0)
                    begin
                        if ((DEG_W+1)'(k_reg) == (DEG_W+1)'(deg) + (DEG_W+1)'(1))
                        begin
                            j_next     = LANE_W'(deg);
                            state_next = ST_SUM_RD;
                        end
                        else
                        begin
                            // next order: lanes k down to 0
                            j_next     = LANE_W'(k_reg);
                            k_next     = k_reg + DEG_W'(1);
                            held_next  = '0;
                            state_next = ST_LANE_RD;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg - LANE_W'(1);
                        held_next  = rdv_reg;
                        state_next = ST_LANE_RD;
                    end
                end
            end

            ST_SUM_RD:
            begin
                bok_next = (s_reg >= CIDX_W'(j_reg)) && (bsum < CIDX_W'(TABLE_DEPTH));
                c_re     = 1'b1;
                c_addr   = (bsum < CIDX_W'(TABLE_DEPTH)) ? bsum : '0;
                cvld_rd_next = (bsum < CIDX_W'(TABLE_DEPTH)) ? vbits_reg[c_addr] : 1'b0;
                b_re       = 1'b1;
                b_addr     = j_reg;
                state_next = ST_SUM_MUL;
            end

            ST_SUM_MUL:
            begin
                if (bok_reg && cvld_rd_reg)
                    term_next = TERM_W'($signed(c_q) * $signed({1'b0, b_q}));
                else
                    term_next = '0;
                state_next = ST_SUM_ACC;
            end

            ST_SUM_ACC:
            begin
                // arithmetic shift floors toward minus infinity
                sum_next = sum_reg + SUM_W'(term_reg >>> FRAC_BITS);
                if (j_reg == '0)
                    state_next = ST_DONE;
                else
                begin
                    j_next     = j_reg - LANE_W'(1);
                    state_next = ST_SUM_RD;
                end
            end

            ST_DONE:
            begin
                // hold until the output register is free
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    res_write_next = wr_reg;
                    res_value_next = wr_reg ? '0 : OUT_W'(sum_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            deg_cfg_reg   <= DEG_W'(3);
            vbits_reg     <= '0;
            res_valid_reg <= 1'b0;
            k_reg         <= '0;
            j_reg         <= '0;
            half_reg      <= 1'b0;
            wr_reg        <= 1'b0;
            cvld_rd_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vbits_reg     <= vbits_next;
            res_valid_reg <= res_valid_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            half_reg      <= half_next;
            wr_reg        <= wr_next;
            cvld_rd_reg   <= cvld_rd_next;
            if (cfg_wr_en)
                deg_cfg_reg <= spline_degree;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg         <= t_next;
        s_reg         <= s_next;
        held_reg      <= held_next;
        rdv_reg       <= rdv_next;
        num1_reg      <= num1_next;
        num2_reg      <= num2_next;
        d1_reg        <= d1_next;
        d2_reg        <= d2_next;
        en1_reg       <= en1_next;
        en2_reg       <= en2_next;
        prod_reg      <= prod_next;
        w_reg         <= w_next;
        acc_reg       <= acc_next;
        bok_reg       <= bok_next;
        term_reg      <= term_next;
        sum_reg       <= sum_next;
        res_value_reg <= res_value_next;
        res_write_reg <= res_write_next;
    end

endmodule

FILE: dv/tb_bspline_basis_weighted_sum.sv
module tb_bspline_basis_weighted_sum
    import bspl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAST_T = (1 << T_W) - 1;
    localparam int KNOT_STEP = (1 << FRAC_BITS) / (NUM_INTERIOR + 1);
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    typedef enum logic {
        REQ_EVAL  = 1'b0,
        REQ_WRITE = 1'b1
    } req_kind_t;

    typedef struct {
        logic signed [OUT_W-1:0] value;
        logic                    wr;
    } spline_result_t;

    typedef struct {
        req_kind_t          kind;
        logic [T_W-1:0]     t;
        logic [CIDX_W-1:0]  idx;
        logic [COEF_W-1:0]  val;
        bit                 known;
        logic [OUT_W-1:0]   known_value;
    } directed_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [DEG_W-1:0]         degree_cfg;
    logic                     req_valid;
    logic                     req_stall;
    logic                     req_type;
    logic [T_W-1:0]           point_t;
    logic [CIDX_W-1:0]        coeff_index;
    logic signed [COEF_W-1:0] coeff_value;
    logic                     res_valid;
    logic                     res_stall;
    logic signed [OUT_W-1:0]  spline_value;
    logic                     was_write;

    bspline_basis_weighted_sum uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .spline_degree(degree_cfg),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_type     (req_type),
        .point_t      (point_t),
        .coeff_index  (coeff_index),
        .coeff_value  (coeff_value),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .spline_value (spline_value),
        .was_write    (was_write)
    );

    spline_result_t   pending_results[$];
    logic [COEF_W-1:0] coeff_shadow[TABLE_DEPTH];
    logic [DEG_W-1:0] degree_shadow;
    int               error_count = 0;
    int               idle_cycles = 0;
    int               burst_left;
    int unsigned      stall_cnt;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint unsigned knot_at(int deg, int j);
        if (j < deg)
            return 0;
        if (j < deg + NUM_INTERIOR)
            return longint'(j - deg + 1);
        return longint'(NUM_INTERIOR + 1);
    endfunction

    function automatic logic signed [OUT_W-1:0] spline_at(logic [T_W-1:0] t);
        int deg, nk, nb, i, k, b;
        longint unsigned one, tt, lo, hi, mi, mi1, mik, d1, d2, acc, num;
        longint unsigned basis[KNOTS_MAX];
        longint sum, p, sat_hi;
        deg = int'(degree_shadow);
        if (deg < 1)
            deg = 1;
        if (deg > MAX_DEGREE)
            deg = MAX_DEGREE;
        nk = 2 * deg + NUM_INTERIOR;
        nb = deg + NUM_INTERIOR - 1;
        one = 64'd1 << FRAC_BITS;
        tt = longint'(t) * (NUM_INTERIOR + 1);
        for (i = 0; i + 1 < nk; i++)
        begin
            lo = knot_at(deg, i) * one;
            hi = knot_at(deg, i + 1) * one;
            basis[i] = (tt >= lo && tt < hi) ? one : 0;
        end
        for (k = 2; k <= deg + 1; k++)
        begin
            for (i = 0; i + k < nk; i++)
            begin
                mi = knot_at(deg, i);
                mi1 = knot_at(deg, i + 1);
                d1 = knot_at(deg, i + k - 1) - mi;
                mik = knot_at(deg, i + k);
                d2 = mik - mi1;
                acc = 0;
                if (d1 > 0 && basis[i] != 0)
                begin
                    num = (tt > mi * one) ? tt - mi * one : 0;
                    acc += (num / d1) * basis[i];
                end
                if (d2 > 0 && basis[i + 1] != 0)
                begin
                    num = (mik * one > tt) ? mik * one - tt : 0;
                    acc += (num / d2) * basis[i + 1];
                end
                basis[i] = acc >> FRAC_BITS;
            end
        end
        sum = longint'($signed(coeff_shadow[0]));
        for (b = 0; b < nb && b + 1 < TABLE_DEPTH; b++)
        begin
            p = longint'($signed(coeff_shadow[b + 1])) * longint'(basis[b]);
            sum += p >>> FRAC_BITS;
        end
        sat_hi = (64'sd1 <<< (OUT_W - 1)) - 1;
        if (sum > sat_hi)
            sum = sat_hi;
        if (sum < -sat_hi - 1)
            sum = -sat_hi - 1;
        return OUT_W'(sum);
    endfunction

    // update the coefficient shadow and return the result this request earns
    function automatic spline_result_t apply_request(req_kind_t kind, logic [T_W-1:0] t,
                                                     logic [CIDX_W-1:0] idx,
                                                     logic [COEF_W-1:0] val);
        spline_result_t r;
        if (kind == REQ_WRITE)
        begin
            if (idx < TABLE_DEPTH)
                coeff_shadow[idx] = val;
            r.value = '0;
            r.wr = 1'b1;
        end
        else
        begin
            r.value = spline_at(t);
            r.wr = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // drive one request, hold until accepted, then maybe drop valid for a gap
    task automatic issue_request(req_kind_t kind, logic [T_W-1:0] t, logic [CIDX_W-1:0] idx,
                                 logic [COEF_W-1:0] val, bit known = 0,
                                 logic [OUT_W-1:0] known_value = '0);
        spline_result_t r;
        int gap;
        req_valid   <= 1'b1;
        req_type    <= kind;
        point_t     <= t;
        coeff_index <= idx;
        coeff_value <= val;
        do
            @(posedge clk);
        while (req_stall);
        r = apply_request(kind, t, idx, val);
        if (known)
            r.value = known_value;
        pending_results = {pending_results, r};
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic set_degree(logic [DEG_W-1:0] d);
        wait_drained();
        cfg_wr_en  <= 1'b1;
        degree_cfg <= d;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        degree_shadow = d;
    endtask

    function automatic logic [T_W-1:0] pick_point();
        case ($urandom_range(0, 5))
            0: return T_W'($urandom_range(0, NUM_INTERIOR + 1) * KNOT_STEP);
            1: return T_W'($urandom_range(0, NUM_INTERIOR + 1) * KNOT_STEP - 1);
            2: return T_W'($urandom_range(1 << FRAC_BITS, LAST_T));
            default: return T_W'($urandom_range(0, (1 << FRAC_BITS) - 1));
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_coeff();
        case ($urandom_range(0, 3))
            0: return COEF_W'($signed($urandom_range(0, 2 << FRAC_BITS)) - (1 << FRAC_BITS));
            1: return {1'b0, {(COEF_W-1){1'b1}}};
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // result check
    always @(posedge clk)
    begin
        spline_result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing outstanding");
            else
            begin
                want = pending_results.pop_front();
                if (was_write !== want.wr)
                    report_mismatch($sformatf("was_write %b, want %b", was_write, want.wr));
                if (spline_value !== want.value)
                    report_mismatch($sformatf("spline_value %0d, want %0d",
                                              spline_value, want.value));
            end
        end
    end

    // result-side backpressure: quiet stretches, light random, a periodic pattern, and heavy random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_cnt <= 0;
            res_stall <= 1'b0;
        end
        else
        begin
            stall_cnt <= stall_cnt + 1;
            case (stall_cnt[10:9])
                2'd0: res_stall <= 1'b0;
                2'd1: res_stall <= ($urandom_range(0, 3) == 0);
                2'd2: res_stall <= stall_cnt[5] & stall_cnt[3];
                default: res_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_bspline_basis_weighted_sum: errors");
            $finish;
        end
    end

    directed_row_t directed[] = '{
        '{REQ_EVAL,  17'd0,      5'd0,  32'h0,        1, 48'd0},
        '{REQ_EVAL,  17'd65536,  5'd0,  32'h0,        1, 48'd0},
        '{REQ_WRITE, 17'd0,      5'd0,  32'h7fffffff, 1, 48'd0},
        '{REQ_EVAL,  17'd65536,  5'd0,  32'h0,        1, 48'h7fffffff},
        '{REQ_EVAL,  17'h1ffff,  5'd0,  32'h0,        1, 48'h7fffffff},
        '{REQ_WRITE, 17'd0,      5'd19, 32'h80000000, 1, 48'd0},
        '{REQ_WRITE, 17'h1ffff,  5'd31, 32'hffffffff, 1, 48'd0},
        '{REQ_WRITE, 17'd0,      5'd20, 32'h12345678, 1, 48'd0},
        '{REQ_WRITE, 17'd0,      5'd1,  32'hffffffff, 1, 48'd0},
        '{REQ_WRITE, 17'd0,      5'd2,  32'h00010000, 1, 48'd0},
        '{REQ_WRITE, 17'd0,      5'd17, 32'h7fffffff, 1, 48'd0},
        '{REQ_WRITE, 17'd0,      5'd18, 32'h80000000, 1, 48'd0},
        '{REQ_EVAL,  17'd0,      5'd0,  32'h0,        0, 48'd0},
        '{REQ_EVAL,  17'd4096,   5'd0,  32'h0,        0, 48'd0},
        '{REQ_EVAL,  17'd4095,   5'd0,  32'h0,        0, 48'd0},
        '{REQ_EVAL,  17'd32768,  5'd0,  32'h0,        0, 48'd0},
        '{REQ_EVAL,  17'd61440,  5'd0,  32'h0,        0, 48'd0},
        '{REQ_EVAL,  17'd65535,  5'd0,  32'h0,        0, 48'd0},
        '{REQ_WRITE, 17'd0,      5'd0,  32'h80000000, 1, 48'd0},
        '{REQ_EVAL,  17'd65536,  5'd0,  32'h0,        1, 48'hffff80000000},
        '{REQ_EVAL,  17'd100,    5'd0,  32'h0,        0, 48'd0}
    };

    logic [DEG_W-1:0] degree_plan[] = '{3'd1, 3'd5, 3'd0, 3'd7, 3'd2, 3'd4, 3'd6, 3'd3};

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        degree_cfg = 3'd3;
        req_valid = 1'b0;
        req_type = REQ_EVAL;
        point_t = '0;
        coeff_index = '0;
        coeff_value = '0;
        burst_left = 0;
        degree_shadow = 3'd3;
        foreach (coeff_shadow[i])
            coeff_shadow[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            issue_request(directed[i].kind, directed[i].t, directed[i].idx, directed[i].val,
                          directed[i].known, directed[i].known_value);

        foreach (degree_plan[p])
        begin
            set_degree(degree_plan[p]);
            for (int n = 0; n < 155; n++)
            begin
                if (n == 70 && p % 3 == 0)
                    wait_drained();
                if ($urandom_range(0, 9) < 3)
                    issue_request(REQ_WRITE, T_W'($urandom), CIDX_W'($urandom),
                                  pick_coeff());
                else
                    issue_request(REQ_EVAL, pick_point(), CIDX_W'($urandom),
                                  COEF_W'($urandom));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb_bspline_basis_weighted_sum: clean");
        else
            $display("tb_bspline_basis_weighted_sum: errors");
        $finish;
    end

endmodule
